@@ hw/rtl/hpsv_pkg.sv @@
// Shared types and character constants for the endpoint string validator.
package hpsv_pkg;

    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    localparam logic [2:0] DOTS_IPV4       = 3'd3;
    localparam logic [2:0] PORT_MAX_DIGITS = 3'd5;
    localparam logic [2:0] DOT_SAT         = 3'd4;
    localparam logic [2:0] PORT_SAT        = 3'd6;

    typedef enum logic [1:0] {
        SEP_NONE  = 2'd0,
        SEP_DOT   = 2'd1,
        SEP_COLON = 2'd2
    } sep_t;

    // Character class of one byte, produced by the front end.
    typedef struct packed {
        logic is_dot;
        logic is_colon;
        logic is_hyphen;
        logic is_dec;
        logic is_hex;
        logic is_allowed;
        logic last;
    } byte_class_t;

    typedef struct packed {
        logic       at_first_byte;
        logic       label_begins;
        logic       all_decimal;
        logic       all_hex;
        logic       in_port;
        logic       ipv6_mode;
        logic [2:0] dot_count;
        logic [2:0] port_digits;
        logic       prev_was_hyphen;
        sep_t       separator_seen;
        logic       rejected;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        at_first_byte:   1'b1,
        label_begins:    1'b1,
        all_decimal:     1'b1,
        all_hex:         1'b1,
        in_port:         1'b0,
        ipv6_mode:       1'b0,
        dot_count:       3'd0,
        port_digits:     3'd0,
        prev_was_hyphen: 1'b0,
        separator_seen:  SEP_NONE,
        rejected:        1'b0
    };

endpackage

@@ hw/rtl/host_port_string_validator.sv @@
// A final byte is registered in the byte queue; its verdict is then registered in the
// result queue before it appears on the result ports.
// Throughput: one byte per cycle while full is low; the scanner's flag update sets it.
// Only a final byte can wait in the back end, and only while the result queue is full.
// Reset clears both queues and scan flags and holds off push until started_reg sets.
module host_port_string_validator #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    output logic       empty,
    input  logic       pop,
    output logic       valid_res
);
    import hpsv_pkg::*;

    localparam int CW = $bits(byte_class_t);

    byte_class_t   cls_in, cls_out;
    logic [CW-1:0] cls_out_bits;
    logic          cls_push, cls_pop, cls_empty, cls_full;
    logic          res_push, res_data, res_full;
    logic          cls_push_ok;

    assign full    = cls_full || !cls_push_ok;

    hpsv_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (1'b1),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .cls_push   (cls_push_ok),
        .cls        (cls_in)
    );

    assign cls_push = push && !full;

    hpsv_queue #(
        .WIDTH (CW),
        .DEPTH (FIFO_DEPTH)
    ) u_cls_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cls_push),
        .wr_data (cls_in),
        .full    (cls_full),
        .rd_en   (cls_pop),
        .rd_data (cls_out_bits),
        .empty   (cls_empty)
    );

    assign cls_out = byte_class_t'(cls_out_bits);

    hpsv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_empty (cls_empty),
        .cls       (cls_out),
        .cls_pop   (cls_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    hpsv_queue #(
        .WIDTH (1),
        .DEPTH (FIFO_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (valid_res),
        .empty   (empty)
    );

endmodule

@@ hw/rtl/hpsv_queue.sv @@
// Small register queue used between the front end, the back end and the result port.
module hpsv_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/hpsv_classify.sv @@
// Front end: sorts each incoming byte into the character classes the scanner needs.
module hpsv_classify (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [7:0]                text_byte,
    input  logic                      final_byte,
    output logic                      cls_push,
    output hpsv_pkg::byte_class_t     cls
);
    import hpsv_pkg::*;

    logic is_dec, is_upper, is_lower, is_hex_alpha;
    logic started_reg;

    assign is_dec       = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign is_upper     = (text_byte >= 8'h41) && (text_byte <= 8'h5A);
    assign is_lower     = (text_byte >= 8'h61) && (text_byte <= 8'h7A);
    assign is_hex_alpha = ((text_byte >= 8'h41) && (text_byte <= 8'h46)) ||
                          ((text_byte >= 8'h61) && (text_byte <= 8'h66));

    always_comb
    begin
        cls.is_dot     = (text_byte == CH_DOT);
        cls.is_colon   = (text_byte == CH_COLON);
        cls.is_hyphen  = (text_byte == CH_HYPHEN);
        cls.is_dec     = is_dec;
        cls.is_hex     = is_dec || is_hex_alpha;
        cls.is_allowed = (text_byte == CH_HYPHEN) || is_dec || is_upper || is_lower;
        cls.last       = final_byte;
    end

    // Writes are held off out of reset until started_reg is set.
    assign cls_push = push && started_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
        end
        else
        begin
            started_reg <= 1'b1;
        end
    end

endmodule

@@ hw/rtl/hpsv_back.sv @@
// Back end: runs the scan flags over each classified byte and forms the verdict.
module hpsv_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cls_empty,
    input  hpsv_pkg::byte_class_t cls,
    output logic                  cls_pop,
    input  logic                  res_full,
    output logic                  res_push,
    output logic                  res_data
);
    import hpsv_pkg::*;

    scan_state_t state_reg, state_next;
    scan_state_t st;
    logic        fire;
    logic        ok;

    // A final byte waits until the result queue has room.
    assign fire     = !cls_empty && (!cls.last || !res_full);
    assign cls_pop  = fire;
    assign res_push = fire && cls.last;
    assign res_data = ok;

    always_comb
    begin
        st = state_reg;
        if (cls.is_dot || cls.is_colon)
        begin
            if (st.at_first_byte)
            begin
                if (cls.is_dot)
                begin
                    st.rejected = 1'b1;
                end
                st.ipv6_mode = 1'b1;
                st.all_hex   = 1'b1;
            end
            if (st.prev_was_hyphen)
            begin
                st.rejected = 1'b1;
            end
            if (cls.is_dot)
            begin
                st.label_begins = 1'b1;
                if (st.dot_count < DOT_SAT)
                begin
                    st.dot_count = st.dot_count + 3'd1;
                end
                st.separator_seen = SEP_DOT;
            end
            else
            begin
                if (st.all_hex && st.separator_seen != SEP_DOT)
                begin
                    st.ipv6_mode      = 1'b1;
                    st.separator_seen = SEP_COLON;
                end
                else if (st.in_port && !st.ipv6_mode)
                begin
                    st.rejected = 1'b1;
                end
                st.in_port     = 1'b1;
                st.port_digits = 3'd0;
            end
        end
        else
        begin
            if (st.label_begins && cls.is_hyphen)
            begin
                st.rejected = 1'b1;
            end
            if (st.in_port)
            begin
                if (!cls.is_dec)
                begin
                    if (st.ipv6_mode)
                    begin
                        st.in_port = 1'b0;
                    end
                    else
                    begin
                        st.rejected = 1'b1;
                    end
                end
                else if (st.port_digits < PORT_SAT)
                begin
                    st.port_digits = st.port_digits + 3'd1;
                end
            end
            if (!cls.is_dec)
            begin
                st.all_decimal = 1'b0;
            end
            if (st.all_hex && !cls.is_hex)
            begin
                if (st.ipv6_mode)
                begin
                    st.rejected = 1'b1;
                end
                st.all_hex = 1'b0;
            end
            if (!cls.is_allowed)
            begin
                st.rejected = 1'b1;
            end
            st.label_begins = 1'b0;
        end
        st.prev_was_hyphen = cls.is_hyphen;
        st.at_first_byte   = 1'b0;

        ok = !st.rejected;
        if (st.all_decimal && st.dot_count != DOTS_IPV4)
        begin
            ok = 1'b0;
        end
        if (st.ipv6_mode && st.dot_count != 3'd0 && st.dot_count != DOTS_IPV4)
        begin
            ok = 1'b0;
        end
        if (st.port_digits == 3'd0 || st.port_digits > PORT_MAX_DIGITS)
        begin
            ok = 1'b0;
        end

        if (!fire)
        begin
            state_next = state_reg;
        end
        else if (cls.last)
        begin
            state_next = SCAN_RESET;
        end
        else
        begin
            state_next = st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/hpsv_checker.sv @@
// Port-level checker for the endpoint string validator, bound to the top level.
module hpsv_checker (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input logic valid_res
);

    // A waiting result transaction is neither dropped nor altered.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(valid_res))
        else $error("waiting result changed or vanished");

    // The input side only backs up behind a final byte that waits for result space.
    a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        full && $past(rst_n) && $past(rst_n, 2) |-> !empty)
        else $error("input queue full with no result waiting");

    // Reset leaves nothing to read and refuses input.
    a_reset_state: assert property (@(posedge clk)
        !rst_n |-> empty && full)
        else $error("bad port state during reset");

endmodule

bind host_port_string_validator hpsv_checker u_hpsv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .valid_res (valid_res)
);

@@ dv/tb.sv @@
// Self-checking testbench for the endpoint string validator, with directed and random strings.
module tb;
    import hpsv_pkg::*;

    localparam int    CYCLE_LIMIT  = 200000;
    localparam int    PHASE_ITEMS  = 450;
    localparam int    TAIL_CYCLES  = 8;
    localparam string DEC_CHARS    = "0123456789";
    localparam string HEX_CHARS    = "0123456789abcdefABCDEF";
    localparam string HOST_CHARS   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";
    localparam string NOISE_CHARS  = ".:-0aZg9F";
    localparam string BREAK_CHARS  = ".:-";

    typedef struct {
        logic [7:0] text;
        logic       last;
    } text_item_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] text_byte;
    logic       final_byte;
    logic       empty;
    logic       pop;
    logic       valid_res;

    text_item_t  pending_q[$];
    logic [7:0]  text_q[$];
    logic        verdict_q[$];
    text_item_t  next_item;
    scan_state_t scan;
    logic        expected_ok;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    host_port_string_validator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .empty      (empty),
        .pop        (pop),
        .valid_res  (valid_res)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("host_port_string_validator: mismatch");
            $finish;
        end
    end

    // Advances the scan flags by one byte and queues the verdict on a final byte.
    task automatic scan_byte(input logic [7:0] c, input logic last);
        logic dig;
        logic hexdig;
        logic allowed;
        logic ok;
        dig = (c >= 8'h30 && c <= 8'h39);
        hexdig = dig || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
        allowed = (c == CH_HYPHEN) || dig || (c >= 8'h41 && c <= 8'h5A)
                  || (c >= 8'h61 && c <= 8'h7A);
        if (c == CH_DOT || c == CH_COLON)
        begin
            if (scan.at_first_byte)
            begin
                if (c == CH_DOT)
                    scan.rejected = 1'b1;
                scan.ipv6_mode = 1'b1;
                scan.all_hex = 1'b1;
            end
            if (scan.prev_was_hyphen)
                scan.rejected = 1'b1;
            if (c == CH_DOT)
            begin
                scan.label_begins = 1'b1;
                if (scan.dot_count < DOT_SAT)
                    scan.dot_count = scan.dot_count + 3'd1;
                scan.separator_seen = SEP_DOT;
            end
            else
            begin
                if (scan.all_hex && scan.separator_seen != SEP_DOT)
                begin
                    scan.ipv6_mode = 1'b1;
                    scan.separator_seen = SEP_COLON;
                end
                else if (scan.in_port && !scan.ipv6_mode)
                    scan.rejected = 1'b1;
                scan.in_port = 1'b1;
                scan.port_digits = 3'd0;
            end
        end
        else
        begin
            if (scan.label_begins && c == CH_HYPHEN)
                scan.rejected = 1'b1;
            if (scan.in_port)
            begin
                if (!dig)
                begin
                    if (scan.ipv6_mode)
                        scan.in_port = 1'b0;
                    else
                        scan.rejected = 1'b1;
                end
                else if (scan.port_digits < PORT_SAT)
                    scan.port_digits = scan.port_digits + 3'd1;
            end
            if (!dig)
                scan.all_decimal = 1'b0;
            if (scan.all_hex && !hexdig)
            begin
                if (scan.ipv6_mode)
                    scan.rejected = 1'b1;
                scan.all_hex = 1'b0;
            end
            if (!allowed)
                scan.rejected = 1'b1;
            scan.label_begins = 1'b0;
        end
        scan.prev_was_hyphen = (c == CH_HYPHEN);
        scan.at_first_byte = 1'b0;
        if (last)
        begin
            ok = !scan.rejected;
            if (scan.all_decimal && scan.dot_count != DOTS_IPV4)
                ok = 1'b0;
            if (scan.ipv6_mode && scan.dot_count != 3'd0 && scan.dot_count != DOTS_IPV4)
                ok = 1'b0;
            if (scan.port_digits < 3'd1 || scan.port_digits > PORT_MAX_DIGITS)
                ok = 1'b0;
            verdict_q.push_back(ok);
            scan = SCAN_RESET;
        end
    endtask

    // Monitor: predicts on every accepted byte and checks every accepted verdict.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                scan_byte(text_byte, final_byte);
            if (pop && !empty)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("valid_res: expected none, actual %0b", valid_res);
                    mismatch_count++;
                end
                else
                begin
                    expected_ok = verdict_q.pop_front();
                    if (valid_res !== expected_ok)
                    begin
                        $error("valid_res: expected %0b, actual %0b", expected_ok, valid_res);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Driver: a byte stays on the ports until its transaction completes.
    always @(posedge clk)
    begin
        if (rst_n && (!push || !full))
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_item = pending_q.pop_front();
                push <= 1'b1;
                text_byte <= next_item.text;
                final_byte <= next_item.last;
            end
            else
            begin
                push <= 1'b0;
                text_byte <= 8'($urandom);
                final_byte <= 1'($urandom);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // Moves the string under construction into the pending queue, last byte marked.
    task automatic commit_text();
        text_item_t item;
        foreach (text_q[i])
        begin
            item.text = text_q[i];
            item.last = (i == text_q.size() - 1);
            pending_q.push_back(item);
        end
        text_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        commit_text();
    endtask

    // Port of one to five digits mostly, sometimes empty or too long.
    task automatic build_port();
        int r;
        int n;
        r = $urandom_range(99);
        n = (r < 5) ? 0 : (r < 12) ? $urandom_range(6, 8) : $urandom_range(1, 5);
        text_q.push_back(CH_COLON);
        repeat (n) text_q.push_back(pick(DEC_CHARS));
    endtask

    task automatic build_dotted_quad(input int n_lab);
        for (int i = 0; i < n_lab; i++)
        begin
            if (i != 0)
                text_q.push_back(CH_DOT);
            repeat ($urandom_range(1, 3)) text_q.push_back(pick(DEC_CHARS));
        end
    endtask

    task automatic fill_random(input int n_items);
        int added;
        int kind;
        int idx;
        added = 0;
        while (added < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                build_dotted_quad(($urandom_range(9) == 0) ? $urandom_range(1, 6) : 4);
                build_port();
            end
            else if (kind < 55)
            begin
                if ($urandom_range(3) == 0)
                    text_q.push_back(CH_COLON);
                for (int g = 0; g < $urandom_range(1, 8); g++)
                begin
                    if (g != 0)
                    begin
                        text_q.push_back(CH_COLON);
                        if ($urandom_range(7) == 0)
                            text_q.push_back(CH_COLON);
                    end
                    repeat ($urandom_range(1, 4)) text_q.push_back(pick(HEX_CHARS));
                end
                if ($urandom_range(4) == 0)
                begin
                    text_q.push_back(CH_COLON);
                    build_dotted_quad(($urandom_range(5) == 0) ? $urandom_range(2, 6) : 4);
                end
                build_port();
            end
            else if (kind < 85)
            begin
                // Occasionally far too many labels, so the dot count saturates.
                for (int l = 0; l < (($urandom_range(7) == 0) ? 7 : $urandom_range(1, 4)); l++)
                begin
                    if (l != 0)
                        text_q.push_back(CH_DOT);
                    repeat ($urandom_range(1, 8)) text_q.push_back(pick(HOST_CHARS));
                end
                build_port();
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    text_q.push_back(($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                                              : pick(NOISE_CHARS));
            end
            // Break some of the well-formed strings at a random position.
            if (kind < 85 && $urandom_range(4) == 0)
            begin
                idx = $urandom_range(text_q.size() - 1);
                text_q[idx] = ($urandom_range(2) == 0) ? 8'($urandom_range(255))
                                                       : pick(BREAK_CHARS);
            end
            added += text_q.size();
            commit_text();
        end
    endtask

    // Holds back new stimulus until every byte is taken and every verdict has arrived.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || push || verdict_q.size() != 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        text_byte = 8'h00;
        final_byte = 1'b0;
        scan = SCAN_RESET;
        tx_idle_pct = 13;
        rx_idle_pct = 88;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A NUL byte and high bytes are never allowed characters.
        text_q.push_back(8'h00);
        commit_text();
        text_q.push_back(8'hFF);
        commit_text();
        text_q.push_back(8'h80);
        commit_text();
        push_text(".:1");
        push_text(":1");
        push_text("-:1");
        push_text("a-:1");
        push_text("1.2.3.4:9");
        fill_random(PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 88;
        rx_idle_pct = 13;
        fill_random(PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_random(PHASE_ITEMS);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("host_port_string_validator: match");
        else
            $display("host_port_string_validator: mismatch");
        $finish;
    end

endmodule
